// File: hw/rtl/ccm_pkg.sv
// ----------------------------------------------------------------------------
// Cubic crossfade mixer package
// Shared constants, register indexes, sequencer states and control struct.
// ----------------------------------------------------------------------------
package ccm_pkg;

  localparam int MAX_CHANNELS_DEF = 8;

  localparam int SAMPLE_W   = 16;
  localparam int FRAME_W    = 24;
  localparam int Q31_W      = 32;
  localparam int PROD_W     = 64;
  localparam int CHCOUNT_W  = 4;
  localparam int CFG_INDEX_W = 1;
  localparam int IN_DATA_W  = 56;

  localparam logic [Q31_W-1:0]  ONE_Q31   = 32'h8000_0000;
  localparam logic [PROD_W-1:0] HALF_Q31  = 64'h0000_0000_4000_0000;
  localparam logic [30:0]       HALF_FRAC = 31'h4000_0000;

  localparam logic [CFG_INDEX_W-1:0] REG_FADE_STEP     = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_CHANNEL_COUNT = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LOAD,
    S_LDW,
    S_SQ,
    S_RSQ,
    S_CUBE,
    S_RG,
    S_MIN,
    S_MOUT,
    S_FIN
  } state_t;

  typedef enum logic [2:0] {
    MUL_LOAD,
    MUL_SQ,
    MUL_CUBE,
    MUL_IN,
    MUL_OUT
  } mul_sel_t;

  typedef struct packed {
    logic     in_ready;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     ld_fade;
    logic     ld_sq;
    logic     ld_gain;
    logic     ld_rin;
    logic     fin;
  } ctrl_t;

endpackage

// File: hw/rtl/cubic_crossfade_mixer.sv
// ----------------------------------------------------------------------------
// Cubic crossfade mixer
// Mixes samples of an incoming and an outgoing track with a cubic gain curve.
// ----------------------------------------------------------------------------
// Each request carries one sample of each track for the same channel. The
// incoming sample is weighted by fade cubed and the outgoing one by one minus
// that, and the result is saturated to 16 bits. The fade level is loaded from
// start_frame times fade_step on a request marked first in tuser, and rises by
// fade_step after each whole frame of channel_count samples, up to 1.0. The
// next request waits until the last has left the sequencer (through S_LOAD
// and S_LDW as well when it loads the fade level), as one 32 by 32 multiplier
// forms the load product, the square, the cube and both mix products in turn.
// in_tready is high only while the block is idle; a finished result waits in
// the output register, and the next request is taken while it waits.
module cubic_crossfade_mixer
  import ccm_pkg::*;
#(
  parameter int MAX_CHANNELS = MAX_CHANNELS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [Q31_W-1:0]       cfg_data,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // incoming_sample [15:0], outgoing_sample [31:16], start_frame [55:32]
  input  logic [IN_DATA_W-1:0]   in_tdata,
  // first_of_block [0]
  input  logic [0:0]             in_tuser,
  input  logic                   in_tlast,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // mixed_sample [15:0]
  output logic [SAMPLE_W-1:0]    out_tdata,
  output logic                   out_tlast
);

  localparam int IW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int CW = $clog2(MAX_CHANNELS + 1);
  localparam logic [4:0] MAX_CH5 = 5'(MAX_CHANNELS);

  ctrl_t ctrl;
  logic  accept;
  logic  out_free;
  logic  fin_go;

  logic [Q31_W-1:0]     fade_step_r;
  logic [CHCOUNT_W-1:0] channel_count_r;
  logic [Q31_W-1:0]     fade_r;
  logic [Q31_W-1:0]     fade_nxt;
  logic [IW-1:0]        chan_r;
  logic [IW-1:0]        chan_nxt;

  logic signed [SAMPLE_W-1:0] in_a_r;
  logic signed [SAMPLE_W-1:0] in_b_r;
  logic [FRAME_W-1:0]         start_r;
  logic                       last_r;
  logic [Q31_W-1:0]           sq_r;
  logic [Q31_W-1:0]           gin_r;
  logic [Q31_W-1:0]           gout_r;
  logic signed [16:0]         rin_r;

  logic                  out_valid_r;
  logic [SAMPLE_W-1:0]   out_data_r;
  logic                  out_last_r;

  logic [Q31_W-1:0]  step_eff;
  logic [4:0]        n5;
  logic [CW-1:0]     n_eff;
  logic [CW-1:0]     chan_inc;
  logic [Q31_W:0]    fade_sum;

  logic [Q31_W-1:0]  op_a;
  logic [Q31_W-1:0]  op_b;
  logic [PROD_W-1:0] prod_r;
  logic [PROD_W-1:0] prod_rnd;
  logic [Q31_W-1:0]  prod_rq;
  logic [Q31_W-1:0]  load_sat;
  logic [Q31_W-1:0]  gin_sat;

  logic [SAMPLE_W-1:0] mag_a;
  logic [SAMPLE_W-1:0] mag_b;
  logic [16:0]         q_in;
  logic                round_up;
  logic [16:0]         q_rnd;

  logic signed [48:0] base;
  logic signed [48:0] pout;
  logic signed [48:0] sum;
  logic signed [17:0] t_fl;
  logic signed [17:0] t_tr;
  logic [SAMPLE_W-1:0] mixed;

  assign accept    = in_tvalid && in_tready;
  assign in_tready = ctrl.in_ready;
  assign out_free  = !out_valid_r || out_tready;
  assign fin_go    = ctrl.fin && out_free;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  ccm_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .first    (in_tuser[0]),
    .out_free (out_free),
    .ctrl     (ctrl)
  );

  ccm_mult u_mult (
    .clk    (clk),
    .en     (ctrl.mul_en),
    .op_a   (op_a),
    .op_b   (op_b),
    .prod_r (prod_r)
  );

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fade_step_r     <= '0;
      channel_count_r <= CHCOUNT_W'(2);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FADE_STEP:     fade_step_r     <= cfg_data;
        REG_CHANNEL_COUNT: channel_count_r <= cfg_data[CHCOUNT_W-1:0];
        default: ;
      endcase
    end
  end

  assign step_eff = (fade_step_r > ONE_Q31) ? ONE_Q31 : fade_step_r;

  always_comb begin
    n5 = {1'b0, channel_count_r};
    if (n5 == 5'd0) begin
      n5 = 5'd1;
    end
    if (n5 > MAX_CH5) begin
      n5 = MAX_CH5;
    end
  end

  assign n_eff = n5[CW-1:0];

  // Operand selection for the shared multiplier.
  assign mag_a = in_a_r[SAMPLE_W-1] ? (~in_a_r + 1'b1) : in_a_r;
  assign mag_b = in_b_r[SAMPLE_W-1] ? (~in_b_r + 1'b1) : in_b_r;

  always_comb begin
    op_a = fade_r;
    op_b = fade_r;
    case (ctrl.mul_sel)
      MUL_LOAD: begin
        op_a = {{(Q31_W-FRAME_W){1'b0}}, start_r};
        op_b = step_eff;
      end
      MUL_SQ: begin
        op_a = fade_r;
        op_b = fade_r;
      end
      MUL_CUBE: begin
        op_a = sq_r;
        op_b = fade_r;
      end
      MUL_IN: begin
        op_a = {{(Q31_W-SAMPLE_W){1'b0}}, mag_a};
        op_b = gin_r;
      end
      MUL_OUT: begin
        op_a = {{(Q31_W-SAMPLE_W){1'b0}}, mag_b};
        op_b = gout_r;
      end
      default: begin
        op_a = fade_r;
        op_b = fade_r;
      end
    endcase
  end

  // Rounding of Q1.31 products, half up.
  assign prod_rnd = prod_r + HALF_Q31;
  assign prod_rq  = prod_rnd[62:31];
  assign load_sat = (prod_r > {{Q31_W{1'b0}}, ONE_Q31}) ? ONE_Q31 : prod_r[Q31_W-1:0];
  assign gin_sat  = (prod_rq > ONE_Q31) ? ONE_Q31 : prod_rq;

  // Incoming product rounded to an integer, ties to even.
  assign q_in     = prod_r[47:31];
  assign round_up = (prod_r[30:0] > HALF_FRAC) ||
                    ((prod_r[30:0] == HALF_FRAC) && q_in[0]);
  assign q_rnd    = q_in + {16'd0, round_up};

  // Final sum, truncated toward zero and saturated.
  assign base = {rin_r[16], rin_r, 31'd0};
  assign pout = {1'b0, prod_r[47:0]};
  assign sum  = in_b_r[SAMPLE_W-1] ? (base - pout) : (base + pout);
  assign t_fl = sum[48:31];
  assign t_tr = t_fl + {17'd0, (sum[48] && (|sum[30:0]))};

  always_comb begin
    if (t_tr > 18'sd32767) begin
      mixed = 16'h7FFF;
    end else if (t_tr < -18'sd32768) begin
      mixed = 16'h8000;
    end else begin
      mixed = t_tr[SAMPLE_W-1:0];
    end
  end

  // Fade and channel position.
  assign chan_inc = CW'(chan_r) + 1'b1;
  assign fade_sum = {1'b0, fade_r} + {1'b0, step_eff};

  always_comb begin
    fade_nxt = fade_r;
    chan_nxt = chan_r;
    if (accept && !in_tuser[0] && (CW'(chan_r) >= n_eff)) begin
      chan_nxt = '0;
    end
    if (ctrl.ld_fade) begin
      fade_nxt = load_sat;
      chan_nxt = '0;
    end
    if (fin_go) begin
      if (chan_inc >= n_eff) begin
        chan_nxt = '0;
        fade_nxt = (fade_sum > {1'b0, ONE_Q31}) ? ONE_Q31 : fade_sum[Q31_W-1:0];
      end else begin
        chan_nxt = chan_inc[IW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fade_r <= '0;
      chan_r <= '0;
    end else begin
      fade_r <= fade_nxt;
      chan_r <= chan_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      in_a_r  <= in_tdata[15:0];
      in_b_r  <= in_tdata[31:16];
      start_r <= in_tdata[55:32];
      last_r  <= in_tlast;
    end
    if (ctrl.ld_sq) begin
      sq_r <= prod_rq;
    end
    if (ctrl.ld_gain) begin
      gin_r  <= gin_sat;
      gout_r <= ONE_Q31 - gin_sat;
    end
    if (ctrl.ld_rin) begin
      rin_r <= in_a_r[SAMPLE_W-1] ? -$signed(q_rnd) : $signed(q_rnd);
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fin_go) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_go) begin
      out_data_r <= mixed;
      out_last_r <= last_r;
    end
  end

endmodule

// File: hw/rtl/ccm_mult.sv
// ----------------------------------------------------------------------------
// Shared multiplier
// Unsigned 32 by 32 multiplier with a registered product.
// ----------------------------------------------------------------------------
module ccm_mult
  import ccm_pkg::*;
(
  input  logic              clk,
  input  logic              en,
  input  logic [Q31_W-1:0]  op_a,
  input  logic [Q31_W-1:0]  op_b,
  output logic [PROD_W-1:0] prod_r
);

  logic [PROD_W-1:0] prod_nxt;

  assign prod_nxt = op_a * op_b;

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= prod_nxt;
    end
  end

endmodule

// File: hw/rtl/ccm_seq.sv
// ----------------------------------------------------------------------------
// Mixer sequencer
// Steps a request via load if first, cube, mix and result on the multiplier.
// ----------------------------------------------------------------------------
module ccm_seq
  import ccm_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  accept,
  input  logic  first,
  input  logic  out_free,
  output ctrl_t ctrl
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = first ? S_LOAD : S_SQ;
        end
      end
      S_LOAD: state_nxt = S_LDW;
      S_LDW:  state_nxt = S_SQ;
      S_SQ:   state_nxt = S_RSQ;
      S_RSQ:  state_nxt = S_CUBE;
      S_CUBE: state_nxt = S_RG;
      S_RG:   state_nxt = S_MIN;
      S_MIN:  state_nxt = S_MOUT;
      S_MOUT: state_nxt = S_FIN;
      S_FIN: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    ctrl = '0;
    ctrl.mul_sel = MUL_SQ;
    unique case (state_r)
      S_IDLE: ctrl.in_ready = 1'b1;
      S_LOAD: begin
        ctrl.mul_en  = 1'b1;
        ctrl.mul_sel = MUL_LOAD;
      end
      S_LDW:  ctrl.ld_fade = 1'b1;
      S_SQ: begin
        ctrl.mul_en  = 1'b1;
        ctrl.mul_sel = MUL_SQ;
      end
      S_RSQ:  ctrl.ld_sq = 1'b1;
      S_CUBE: begin
        ctrl.mul_en  = 1'b1;
        ctrl.mul_sel = MUL_CUBE;
      end
      S_RG:   ctrl.ld_gain = 1'b1;
      S_MIN: begin
        ctrl.mul_en  = 1'b1;
        ctrl.mul_sel = MUL_IN;
      end
      S_MOUT: begin
        ctrl.mul_en  = 1'b1;
        ctrl.mul_sel = MUL_OUT;
        ctrl.ld_rin  = 1'b1;
      end
      S_FIN:  ctrl.fin = 1'b1;
      default: ctrl.in_ready = 1'b0;
    endcase
  end

endmodule

// File: bench/cubic_crossfade_mixer_test.sv
// ----------------------------------------------------------------------------
// Cubic crossfade mixer testbench
// Directed and random sample blocks go through the mixer under several fade
// steps and channel counts. Each accepted request is predicted with a local
// model of the fade level and the cubic gain. Each result is checked in order,
// with random idling on both sides and two long output stalls.
// ----------------------------------------------------------------------------
module cubic_crossfade_mixer_test;
  import ccm_pkg::*;

  typedef struct {
    logic signed [SAMPLE_W-1:0] in_smp;
    logic signed [SAMPLE_W-1:0] out_smp;
    logic [FRAME_W-1:0]         start;
    logic                       first;
    logic                       last;
  } mix_req_t;

  typedef struct {
    logic [SAMPLE_W-1:0] mixed;
    logic                block_end;
  } mixed_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = REG_FADE_STEP;
  logic [Q31_W-1:0]       cfg_data = '0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_DATA_W-1:0]   in_tdata = '0;
  logic [0:0]             in_tuser = '0;
  logic                   in_tlast = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [SAMPLE_W-1:0]    out_tdata;
  logic                   out_tlast;

  mix_req_t mix_req_q[$];
  mixed_t   mixed_q[$];
  mix_req_t cur_req;

  logic [Q31_W-1:0]     step_reg = '0;
  logic [CHCOUNT_W-1:0] chan_cfg = 4'd2;
  logic [Q31_W-1:0]     fade_lvl = '0;
  int                   chan_pos = 0;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int holdoff_arm = 0;
  int holdoff_seen = 0;
  int holdoff_left = 0;
  int n_queued = 0;
  int n_done = 0;
  int errors = 0;

  cubic_crossfade_mixer dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always #10 clk = ~clk;

  function automatic logic [63:0] clamp_one(input logic [63:0] v);
    return (v > 64'(ONE_Q31)) ? 64'(ONE_Q31) : v;
  endfunction

  function automatic int frame_width();
    if (chan_cfg == 0) return 1;
    if (chan_cfg > MAX_CHANNELS_DEF) return MAX_CHANNELS_DEF;
    return int'(chan_cfg);
  endfunction

  function automatic mixed_t predict_mix(input mix_req_t r);
    logic [63:0]        step;
    logic [63:0]        f;
    logic [63:0]        sq;
    logic [63:0]        gin;
    logic [63:0]        gout;
    logic [63:0]        imag;
    logic [63:0]        q;
    logic [63:0]        smag;
    logic [63:0]        t;
    longint             mag;
    longint             rin;
    longint             po;
    longint             sum;
    logic               ineg;
    logic               sneg;
    logic signed [31:0] m;
    int                 n;
    mixed_t             res;
    step = clamp_one(64'(step_reg));
    n = frame_width();
    if (r.first) begin
      fade_lvl = 32'(clamp_one(64'(r.start) * step));
      chan_pos = 0;
    end
    if (chan_pos >= n) chan_pos = 0;
    f = 64'(fade_lvl);
    sq = (f * f + HALF_Q31) >> 31;
    gin = clamp_one((sq * f + HALF_Q31) >> 31);
    gout = 64'(ONE_Q31) - gin;
    ineg = r.in_smp < 0;
    mag = ineg ? -longint'(r.in_smp) : longint'(r.in_smp);
    imag = 64'(mag) * gin;
    q = imag >> 31;
    if (imag[30:0] > HALF_FRAC || (imag[30:0] == HALF_FRAC && q[0])) q = q + 1;
    rin = ineg ? -longint'(q) : longint'(q);
    po = longint'(r.out_smp) * longint'(gout);
    sum = rin * (longint'(1) <<< 31) + po;
    sneg = sum < 0;
    smag = sneg ? 64'(-sum) : 64'(sum);
    t = smag >> 31;
    if (!sneg && t > 64'd32767) m = 32767;
    else if (sneg && t > 64'd32768) m = -32768;
    else m = sneg ? -int'(t) : int'(t);
    res.mixed = m[SAMPLE_W-1:0];
    res.block_end = r.last;
    chan_pos++;
    if (chan_pos >= n) begin
      chan_pos = 0;
      fade_lvl = 32'(clamp_one(f + step));
    end
    return res;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) mixed_q.push_back(predict_mix(cur_req));
      if (!in_tvalid || in_tready) begin
        if (mix_req_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          cur_req = mix_req_q.pop_front();
          in_tdata <= {cur_req.start, cur_req.out_smp, cur_req.in_smp};
          in_tuser <= cur_req.first;
          in_tlast <= cur_req.last;
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (holdoff_arm != holdoff_seen) begin
      holdoff_seen <= holdoff_arm;
      holdoff_left <= 300;
    end else if (holdoff_left != 0) begin
      holdoff_left <= holdoff_left - 1;
    end
  end

  always @(posedge clk) begin : result_check
    mixed_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= (holdoff_left == 0) && ($urandom_range(99) >= recv_stall_pct);
      if (out_tvalid && out_tready) begin
        if (mixed_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, actual mixed %h last %b",
                   $time, out_tdata, out_tlast);
        end else begin
          want = mixed_q.pop_front();
          n_done++;
          if (out_tdata !== want.mixed) begin
            errors++;
            $display("%0t: mixed_sample expected %h actual %h", $time, want.mixed, out_tdata);
          end
          if (out_tlast !== want.block_end) begin
            errors++;
            $display("%0t: block_end expected %b actual %b", $time, want.block_end, out_tlast);
          end
        end
      end
    end
  end

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [Q31_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_FADE_STEP) step_reg = val;
    else chan_cfg = val[CHCOUNT_W-1:0];
  endtask

  task automatic queue_req(input logic [15:0] a, input logic [15:0] b,
                           input logic [FRAME_W-1:0] start, input logic first,
                           input logic last);
    mix_req_t r;
    r.in_smp = a;
    r.out_smp = b;
    r.start = start;
    r.first = first;
    r.last = last;
    mix_req_q.push_back(r);
    n_queued++;
  endtask

  task automatic drain();
    while (n_done != n_queued) @(posedge clk);
  endtask

  function automatic logic [15:0] pick_sample();
    case ($urandom_range(9))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'(int'($urandom_range(4)) - 2);
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    int ph;
    int cnt;
    int len;
    int k;
    logic [FRAME_W-1:0] start;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    write_reg(REG_FADE_STEP, 32'h0200_0000);
    write_reg(REG_CHANNEL_COUNT, 32'd2);
    queue_req(16'h7FFF, 16'h8000, 24'd0, 1'b1, 1'b0);
    queue_req(16'h8000, 16'h7FFF, 24'hABCDEF, 1'b0, 1'b0);
    queue_req(16'h8000, 16'h7FFF, 24'd64, 1'b1, 1'b0);
    queue_req(16'h7FFF, 16'h8000, 24'd0, 1'b0, 1'b1);
    queue_req(16'h8000, 16'h8000, 24'd32, 1'b1, 1'b0);
    queue_req(16'h3039, 16'hFFFF, 24'd0, 1'b0, 1'b0);
    queue_req(16'hFFFF, 16'h0001, 24'hFFFFFF, 1'b1, 1'b0);
    queue_req(16'h0001, 16'hFFFF, 24'd0, 1'b0, 1'b1);
    queue_req(16'h1234, 16'h8000, 24'd5, 1'b0, 1'b0);
    queue_req(16'h7FFF, 16'h7FFF, 24'd0, 1'b0, 1'b1);
    drain();
    write_reg(REG_FADE_STEP, 32'hFFFF_FFFF);
    write_reg(REG_CHANNEL_COUNT, 32'd0);
    queue_req(16'h7FFF, 16'h8000, 24'd0, 1'b1, 1'b0);
    queue_req(16'h7FFF, 16'h8000, 24'd0, 1'b0, 1'b0);
    queue_req(16'h0000, 16'h7FFF, 24'd1, 1'b1, 1'b1);
    drain();
    write_reg(REG_FADE_STEP, 32'd1);
    write_reg(REG_CHANNEL_COUNT, 32'd15);
    for (k = 0; k < 9; k++)
      queue_req(pick_sample(), pick_sample(), 24'hFFFFFF, k == 0, k == 8);
    drain();

    for (ph = 0; ph < 10; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct <= 0;  recv_stall_pct <= 0;  end
        1: begin send_idle_pct <= 62; recv_stall_pct <= 0;  end
        2: begin send_idle_pct <= 0;  recv_stall_pct <= 62; end
        default: begin send_idle_pct <= 33; recv_stall_pct <= 33; end
      endcase
      case (ph)
        0: write_reg(REG_FADE_STEP, ONE_Q31);
        1: write_reg(REG_FADE_STEP, 32'd0);
        5: write_reg(REG_FADE_STEP, $urandom);
        9: write_reg(REG_FADE_STEP, 32'hFFFF_FFFF);
        default: write_reg(REG_FADE_STEP, ONE_Q31 / $urandom_range(100, 1));
      endcase
      case (ph)
        0: write_reg(REG_CHANNEL_COUNT, 32'd1);
        1: write_reg(REG_CHANNEL_COUNT, 32'd8);
        3: write_reg(REG_CHANNEL_COUNT, 32'd0);
        7: write_reg(REG_CHANNEL_COUNT, {20'd0, 8'($urandom_range(255)), 4'd15});
        default: write_reg(REG_CHANNEL_COUNT, 32'($urandom_range(8, 1)));
      endcase
      if (ph == 2 || ph == 6) holdoff_arm <= holdoff_arm + 1;
      cnt = 0;
      while (cnt < 40) begin
        k = $urandom_range(9);
        start = ($urandom_range(9) < 7) ? FRAME_W'($urandom_range(150)) : FRAME_W'($urandom);
        if (k < 8) begin
          len = $urandom_range(6, 1) * frame_width();
          for (int i = 0; i < len; i++)
            queue_req(pick_sample(), pick_sample(), (i == 0) ? start : FRAME_W'($urandom),
                      (k < 7) && (i == 0), i == len - 1);
        end else begin
          len = $urandom_range(4, 1);
          for (int i = 0; i < len; i++)
            queue_req(pick_sample(), pick_sample(), FRAME_W'($urandom),
                      1'($urandom_range(1)), 1'($urandom_range(1)));
        end
        cnt += len;
      end
      drain();
    end

    repeat (20) @(posedge clk);
    if (errors == 0) $display("cubic_crossfade_mixer_test OK");
    else $display("cubic_crossfade_mixer_test NOT OK");
    $finish;
  end

  initial begin
    #4_000_000;
    $display("cubic_crossfade_mixer_test NOT OK");
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/ccm_pkg.sv
hw/rtl/ccm_mult.sv
hw/rtl/ccm_seq.sv
hw/rtl/cubic_crossfade_mixer.sv
bench/cubic_crossfade_mixer_test.sv
